FILE: hw/rtl/qpbi_pkg.sv
`timescale 1ns / 1ps

package qpbi_pkg;

   // Block geometry in half-pel samples
   localparam int COLS = 19;
   localparam int ROWS = 19;

   // Position counter width and line store address width
   localparam int POS_W   = 6;
   localparam int LINE_AW = (COLS > 1) ? $clog2(COLS) : 1;

   localparam logic [POS_W-1:0] LAST_COL = POS_W'(COLS - 1);
   localparam logic [POS_W-1:0] LAST_ROW = POS_W'(ROWS - 1);

   typedef struct packed {
      logic [7:0] sample;
      logic       first;
   } req_type;

   typedef struct packed {
      logic [7:0]       full_value;
      logic [7:0]       horiz_value;
      logic             horiz_valid;
      logic [7:0]       vert_value;
      logic             vert_valid;
      logic [7:0]       diag_value;
      logic             diag_valid;
      logic [POS_W-1:0] row_index;
      logic [POS_W-1:0] col_index;
      logic             last;
   } rsp_type;

   // Rounded average of two samples: (a + b + 1) >> 1
   function automatic logic [7:0] avg2(input logic [7:0] a, input logic [7:0] b);
      logic [8:0] sum;
      sum = {1'b0, a} + {1'b0, b} + 9'd1;
      return sum[8:1];
   endfunction

endpackage

FILE: hw/rtl/qpbi_core.sv
`timescale 1ns / 1ps

module qpbi_core import qpbi_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    accept,
   input  req_type req_word,
   output rsp_type rsp_word
);

   logic [7:0]       line_ff [COLS];
   logic [7:0]       left_ff;
   logic [7:0]       above_left_ff;
   logic [POS_W-1:0] row_ff;
   logic [POS_W-1:0] col_ff;
   logic [POS_W-1:0] row_in;
   logic [POS_W-1:0] col_in;

   logic [POS_W-1:0] row_cur;
   logic [POS_W-1:0] col_cur;
   logic [LINE_AW-1:0] line_addr;
   logic [7:0]       cur;
   logic [7:0]       above;
   logic [7:0]       diag;
   logic             hv;
   logic             vv;

   // Restart position on first, then look up the sample above
   always_comb begin
      row_cur   = req_word.first ? '0 : row_ff;
      col_cur   = req_word.first ? '0 : col_ff;
      line_addr = col_cur[LINE_AW-1:0];
      cur       = req_word.sample;
      above     = line_ff[line_addr];
      hv        = (col_cur != '0);
      vv        = (row_cur != '0);
      // Even parity: anti-diagonal (above, left); odd: main diagonal (above-left, current)
      if ((row_cur[0] ^ col_cur[0]) == 1'b0) begin
         diag = avg2(above, left_ff);
      end else begin
         diag = avg2(above_left_ff, cur);
      end
   end

   // Build the result word; invalid averages read as zero
   always_comb begin
      rsp_word.full_value  = cur;
      rsp_word.horiz_value = hv ? avg2(left_ff, cur) : 8'd0;
      rsp_word.horiz_valid = hv;
      rsp_word.vert_value  = vv ? avg2(above, cur) : 8'd0;
      rsp_word.vert_valid  = vv;
      rsp_word.diag_value  = (hv && vv) ? diag : 8'd0;
      rsp_word.diag_valid  = hv && vv;
      rsp_word.row_index   = row_cur;
      rsp_word.col_index   = col_cur;
      rsp_word.last        = (row_cur == LAST_ROW) && (col_cur == LAST_COL);
   end

   // Advance raster position, wrapping at row and block end
   always_comb begin
      if (col_cur == LAST_COL) begin
         col_in = '0;
         row_in = (row_cur == LAST_ROW) ? '0 : row_cur + POS_W'(1);
      end else begin
         col_in = col_cur + POS_W'(1);
         row_in = row_cur;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff        <= '0;
         col_ff        <= '0;
         left_ff       <= '0;
         above_left_ff <= '0;
      end else if (accept) begin
         row_ff        <= row_in;
         col_ff        <= col_in;
         left_ff       <= cur;
         above_left_ff <= above;
      end
   end

   // Store the current sample for the next row
   always_ff @(posedge clock) begin
      if (accept) begin
         line_ff[line_addr] <= cur;
      end
   end

endmodule

FILE: hw/rtl/quarter_pel_bilinear_interpolator.sv
`timescale 1ns / 1ps

// Quarter-pel bilinear interpolator.
// Input channel req_*: one half-pel sample per word, raster order over a
// ROWS x COLS block; req_data.first restarts the position at row 0, column 0.
// Result channel rsp_*: one word per input word carrying the sample, the
// horizontal, vertical and diagonal rounded averages with valid flags, the
// row and column index, and a last flag on the final sample of the block.
// Results are registered in the result or skid register. Throughput: one
// word per cycle while rsp_ready is high, set by the single registered pass
// through the averaging logic and the one-entry-per-cycle line store.
// A two-entry output buffer (result register plus skid register) lets one
// more word in while rsp_ready is low; req_ready drops once both are full
// and rises again as soon as the receiver takes a word.
// Reset clears the position counters, the left and above-left samples and
// the output buffer. The line store is not cleared; it is always written on
// a row before it is read.

module quarter_pel_bilinear_interpolator import qpbi_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   rsp_type core_word;
   rsp_type out_ff;
   rsp_type out_in;
   rsp_type skid_ff;
   rsp_type skid_in;
   logic    out_valid_ff;
   logic    out_valid_in;
   logic    skid_valid_ff;
   logic    skid_valid_in;
   logic    push;
   logic    pop;

   assign req_ready = !skid_valid_ff;
   assign push      = req_valid && req_ready;
   assign pop       = out_valid_ff && rsp_ready;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   qpbi_core u_core (
      .clock    (clock),
      .reset    (reset),
      .accept   (push),
      .req_word (req_data),
      .rsp_word (core_word)
   );

   // Refill the result register from skid first, else from the core
   always_comb begin
      out_in        = out_ff;
      skid_in       = skid_ff;
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (!out_valid_ff || pop) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_in       = core_word;
            skid_valid_in = push;
         end else begin
            out_in        = core_word;
            out_valid_in  = push;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         // Hold the stalled result, park the new word
         skid_in       = core_word;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   // Skid register only fills behind an occupied result register
   assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid word present without a result word");

   // Reported position stays inside the block
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.col_index <= LAST_COL) && (rsp_data.row_index <= LAST_ROW))
      else $error("result position outside the block");

   // Valid flags follow the reported position
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.horiz_valid == (rsp_data.col_index != '0)) &&
                    (rsp_data.vert_valid == (rsp_data.row_index != '0)) &&
                    (rsp_data.diag_valid == (rsp_data.horiz_valid && rsp_data.vert_valid)))
      else $error("valid flags disagree with position");

endmodule
